>>> design/lnps_pkg.sv
package lnps_pkg;

  // Fixed sizes of the voice.
  localparam int NOTE_SLOTS       = 128;
  localparam int NOTE_W           = $clog2(NOTE_SLOTS);
  localparam int COUNT_W          = NOTE_W + 1;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int PHASE_BITS       = 32;

  // Held-map scan: one chunk of the map per cycle.
  localparam int CHUNK_W    = 8;
  localparam int CHUNK_IW   = $clog2(CHUNK_W);
  localparam int CHUNKS     = NOTE_SLOTS / CHUNK_W;
  localparam int CHUNK_CW   = $clog2(CHUNKS);

  // Sine table geometry: largest power of two not above the requested depth.
  localparam int TABLE_BITS  = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int POS_BITS    = TABLE_BITS - 2;
  localparam int QUARTER_LEN = 1 << POS_BITS;
  localparam int SINE_W      = 15;
  localparam int SAMPLE_W    = 16;

  // Configuration registers.
  localparam int RATE_W       = 18;
  localparam int GAIN_W       = 15;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;
  localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(44100);
  localparam logic [GAIN_W-1:0] DEFAULT_GAIN = GAIN_W'(2621);
  localparam logic REG_RATE = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  // Pitch and phase step division.
  localparam int FREQ_W  = 30;
  localparam int OCT_W   = 4;
  localparam int SEMI_W  = 4;
  localparam int STEP_SH = PHASE_BITS - 16;
  localparam int DVD_W   = FREQ_W + STEP_SH + 1;
  localparam int DIV_CW  = $clog2(DVD_W);
  localparam int REM_W   = RATE_W + 1;

  localparam logic [FREQ_W-1:0] TOP_OCTAVE_Q16 [12] = '{
    30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
    30'd691279090, 30'd732384684, 30'd775934544, 30'd822073998,
    30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
  };

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    FUNC_NOTE_ON  = 2'd0,
    FUNC_NOTE_OFF = 2'd1,
    FUNC_SNAPSHOT = 2'd2,
    FUNC_TICK     = 2'd3
  } func_e;

  typedef struct packed {
    logic capture;
    logic map_set;
    logic map_clr;
    logic scan_start;
    logic scan_step;
    logic scan_fin;
    logic div_step;
    logic step_load;
    logic sine_look;
    logic mul;
    logic round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  scan_last;
    logic  found;
    logic  div_last;
    logic  latched_valid;
  } stat_t;

  // Quarter-wave sine in Q15, evaluated once at elaboration by a Taylor
  // series in Q30 up to the eleventh power.
  function automatic logic [(QUARTER_LEN+1)*SINE_W-1:0] build_qsine();
    logic [(QUARTER_LEN+1)*SINE_W-1:0] tab;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    tab = '0;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / QUARTER_LEN;
      term = x;
      sum  = $signed(x);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 6;
      sum  = sum - $signed(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 20;
      sum  = sum + $signed(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 42;
      sum  = sum - $signed(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 72;
      sum  = sum + $signed(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k*SINE_W +: SINE_W] = v[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam logic [(QUARTER_LEN+1)*SINE_W-1:0] QSINE = build_qsine();

endpackage

>>> design/lnps_if.sv
interface voice_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] note_number;

  modport source (output valid, output func, output note_number, input ready);
  modport sink   (input valid, input func, input note_number, output ready);
endinterface

interface voice_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_value;
  logic [7:0]        active_count;
  logic [7:0]        peak_count;
  logic [6:0]        lowest_note;
  logic              note_valid;

  modport source (output valid, output sample_value, output active_count,
                  output peak_count, output lowest_note, output note_valid,
                  input ready);
  modport sink   (input valid, input sample_value, input active_count,
                  input peak_count, input lowest_note, input note_valid,
                  output ready);
endinterface

>>> design/lnps_ctrl.sv
module lnps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lnps_pkg::stat_t   stat_i,
  output lnps_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DECODE   = 9'b000000010,
    ST_SCAN     = 9'b000000100,
    ST_SCAN_FIN = 9'b000001000,
    ST_DIV      = 9'b000010000,
    ST_STEP     = 9'b000100000,
    ST_MUL      = 9'b001000000,
    ST_ROUND    = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.func)
          lnps_pkg::FUNC_NOTE_ON: begin
            cmd_o.map_set = 1'b1;
            state_d       = ST_OUT;
          end
          lnps_pkg::FUNC_NOTE_OFF: begin
            cmd_o.map_clr = 1'b1;
            state_d       = ST_OUT;
          end
          lnps_pkg::FUNC_SNAPSHOT: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          lnps_pkg::FUNC_TICK: begin
            if (stat_i.latched_valid) begin
              cmd_o.sine_look = 1'b1;
              state_d         = ST_MUL;
            end else begin
              state_d = ST_OUT;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_SCAN_FIN;
        end
      end
      ST_SCAN_FIN: begin
        cmd_o.scan_fin = 1'b1;
        state_d        = stat_i.found ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step_load = 1'b1;
        state_d         = ST_OUT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/lnps_dpath.sv
module lnps_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lnps_pkg::cmd_t                      cmd_i,
  output lnps_pkg::stat_t                     stat_o,
  input  logic [1:0]                          in_func_i,
  input  logic [lnps_pkg::NOTE_W-1:0]         in_note_i,
  output logic signed [lnps_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic [lnps_pkg::COUNT_W-1:0]        out_active_o,
  output logic [lnps_pkg::COUNT_W-1:0]        out_peak_o,
  output logic [lnps_pkg::NOTE_W-1:0]         out_lowest_o,
  output logic                                out_note_valid_o,
  input  logic                                cfg_write_i,
  input  logic                                cfg_addr_i,
  input  logic [lnps_pkg::APB_DW-1:0]         cfg_wdata_i,
  output logic [lnps_pkg::APB_DW-1:0]         cfg_rdata_o
);

  localparam int NW  = lnps_pkg::NOTE_W;
  localparam int CW  = lnps_pkg::COUNT_W;
  localparam int PB  = lnps_pkg::PHASE_BITS;
  localparam int TB  = lnps_pkg::TABLE_BITS;
  localparam int PS  = lnps_pkg::POS_BITS;
  localparam int SW  = lnps_pkg::SINE_W;
  localparam int DW  = lnps_pkg::DVD_W;
  localparam int RW  = lnps_pkg::RATE_W;
  localparam int GW  = lnps_pkg::GAIN_W;
  localparam int FW  = lnps_pkg::FREQ_W;
  localparam int KW  = lnps_pkg::CHUNK_W;
  localparam int KIW = lnps_pkg::CHUNK_IW;
  localparam int KCW = lnps_pkg::CHUNK_CW;
  localparam int QW  = lnps_pkg::REM_W;

  // Configuration and architectural state.
  logic [RW-1:0]                   rate_q;
  logic [GW-1:0]                   gain_q;
  logic [lnps_pkg::NOTE_SLOTS-1:0] held_q;
  logic [PB-1:0]                   phase_acc_q;
  logic [PB-1:0]                   phase_step_q;
  logic [NW-1:0]                   latched_note_q;
  logic                            latched_valid_q;
  logic [CW-1:0]                   count_now_q;
  logic [CW-1:0]                   count_peak_q;

  // Working registers.
  lnps_pkg::func_e                 func_q;
  logic [NW-1:0]                   note_q;
  logic [lnps_pkg::NOTE_SLOTS-1:0] scan_q;
  logic [KCW-1:0]                  chunk_idx_q;
  logic [CW-1:0]                   cnt_q;
  logic                            found_q;
  logic [NW-1:0]                   low_q;
  logic [DW-1:0]                   dvd_q;
  logic [RW-1:0]                   rem_q;
  logic [PB-1:0]                   quo_q;
  logic [lnps_pkg::DIV_CW-1:0]     div_cnt_q;
  logic [SW-1:0]                   s_mag_q;
  logic                            s_neg_q;
  logic [2*SW-1:0]                 prod_q;
  logic signed [lnps_pkg::SAMPLE_W-1:0] sample_q;

  // Output register.
  logic signed [lnps_pkg::SAMPLE_W-1:0] o_sample_q;
  logic [CW-1:0]                   o_active_q;
  logic [CW-1:0]                   o_peak_q;
  logic [NW-1:0]                   o_lowest_q;
  logic                            o_valid_q;

  // Scan of the bottom chunk of the shifting map copy.
  logic [KW-1:0]  chunk;
  logic [KIW:0]   chunk_pop;
  logic [KIW-1:0] chunk_ffs;

  always_comb begin
    chunk     = scan_q[KW-1:0];
    chunk_pop = '0;
    chunk_ffs = '0;
    for (int i = 0; i < KW; i++) begin
      chunk_pop = chunk_pop + (KIW+1)'(chunk[i]);
    end
    for (int i = KW - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        chunk_ffs = KIW'(i);
      end
    end
  end

  // Pitch of the lowest note: octave by reciprocal multiply, then a rounded
  // shift of the top-octave entry.
  logic [RW-1:0]        eff_rate;
  logic [NW+7:0]        oct_prod;
  logic [lnps_pkg::OCT_W-1:0]  octave;
  logic [lnps_pkg::SEMI_W-1:0] semi;
  logic [lnps_pkg::OCT_W-1:0]  shift;
  logic [FW-1:0]        f_top;
  logic [FW-1:0]        f_half;
  logic [FW:0]          f_sum;
  logic [FW-1:0]        f_note;
  logic [DW-1:0]        dividend;

  always_comb begin
    eff_rate = (rate_q == '0) ? lnps_pkg::DEFAULT_RATE : rate_q;
    oct_prod = (NW+8)'(low_q) * (NW+8)'(171);
    octave   = oct_prod[NW+7 -: lnps_pkg::OCT_W];
    semi     = lnps_pkg::SEMI_W'(low_q - NW'(octave) * NW'(12));
    shift    = 4'd10 - octave;
    f_top    = lnps_pkg::TOP_OCTAVE_Q16[semi];
    f_half   = (shift == '0) ? '0 : (FW'(1) << (shift - 4'd1));
    f_sum    = ((FW+1)'(f_top) + (FW+1)'(f_half)) >> shift;
    f_note   = f_sum[FW-1:0];
    dividend = (DW'(f_note) << lnps_pkg::STEP_SH) + DW'(eff_rate >> 1);
  end

  // One restoring division step per cycle.
  logic [QW-1:0] trial;
  logic          q_bit;
  logic [QW-1:0] trial_sub;

  always_comb begin
    trial     = {rem_q, dvd_q[DW-1]};
    q_bit     = (trial >= QW'(eff_rate));
    trial_sub = trial - QW'(eff_rate);
  end

  // Quarter-wave lookup from the top phase bits.
  logic [TB-1:0] sine_idx;
  logic [1:0]    quad;
  logic [PS-1:0] pos;
  logic [PS:0]   tab_idx;

  always_comb begin
    sine_idx = phase_acc_q[PB-1 -: TB];
    quad     = sine_idx[TB-1 -: 2];
    pos      = sine_idx[PS-1:0];
    tab_idx  = quad[0] ? ((PS+1)'(lnps_pkg::QUARTER_LEN) - (PS+1)'(pos)) : (PS+1)'(pos);
  end

  logic [2*SW-1:0] rounded;
  logic [SW-1:0]   scaled;

  always_comb begin
    rounded = prod_q + (2*SW)'(16384);
    scaled  = rounded[2*SW-1 -: SW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q          <= lnps_pkg::DEFAULT_RATE;
      gain_q          <= lnps_pkg::DEFAULT_GAIN;
      held_q          <= '0;
      phase_acc_q     <= '0;
      phase_step_q    <= '0;
      latched_note_q  <= '0;
      latched_valid_q <= 1'b0;
      count_now_q     <= '0;
      count_peak_q    <= '0;
    end else begin
      if (cfg_write_i) begin
        unique case (cfg_addr_i)
          lnps_pkg::REG_RATE: begin
            rate_q      <= cfg_wdata_i[RW-1:0];
            phase_acc_q <= '0;
          end
          lnps_pkg::REG_GAIN: gain_q <= cfg_wdata_i[GW-1:0];
          default: ;
        endcase
      end else if (cmd_i.mul) begin
        phase_acc_q <= phase_acc_q + phase_step_q;
      end
      if (cmd_i.map_set) begin
        held_q[note_q] <= 1'b1;
      end
      if (cmd_i.map_clr) begin
        held_q[note_q] <= 1'b0;
      end
      if (cmd_i.scan_fin) begin
        count_now_q     <= cnt_q;
        latched_valid_q <= found_q;
        latched_note_q  <= found_q ? low_q : '0;
        if (cnt_q > count_peak_q) begin
          count_peak_q <= cnt_q;
        end
      end
      if (cmd_i.step_load) begin
        phase_step_q <= quo_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= lnps_pkg::func_e'(in_func_i);
      note_q   <= in_note_i;
      sample_q <= '0;
    end
    if (cmd_i.scan_start) begin
      scan_q      <= held_q;
      chunk_idx_q <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      low_q       <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q      <= scan_q >> KW;
      chunk_idx_q <= chunk_idx_q + KCW'(1);
      cnt_q       <= cnt_q + CW'(chunk_pop);
      if (!found_q && (chunk != '0)) begin
        found_q <= 1'b1;
        low_q   <= {chunk_idx_q, chunk_ffs};
      end
    end
    if (cmd_i.scan_fin) begin
      dvd_q     <= dividend;
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q     <= dvd_q << 1;
      rem_q     <= q_bit ? trial_sub[RW-1:0] : trial[RW-1:0];
      quo_q     <= {quo_q[PB-2:0], q_bit};
      div_cnt_q <= div_cnt_q + lnps_pkg::DIV_CW'(1);
    end
    if (cmd_i.sine_look) begin
      s_mag_q <= lnps_pkg::QSINE[tab_idx*SW +: SW];
      s_neg_q <= quad[1];
    end
    if (cmd_i.mul) begin
      prod_q <= (2*SW)'(gain_q) * (2*SW)'(s_mag_q);
    end
    if (cmd_i.round) begin
      sample_q <= s_neg_q ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
    end
    if (cmd_i.out_load) begin
      o_sample_q <= sample_q;
      o_active_q <= count_now_q;
      o_peak_q   <= count_peak_q;
      o_lowest_q <= latched_note_q;
      o_valid_q  <= latched_valid_q;
    end
  end

  always_comb begin
    stat_o.func          = func_q;
    stat_o.scan_last     = (chunk_idx_q == KCW'(lnps_pkg::CHUNKS - 1));
    stat_o.found         = found_q;
    stat_o.div_last      = (div_cnt_q == lnps_pkg::DIV_CW'(DW - 1));
    stat_o.latched_valid = latched_valid_q;
  end

  always_comb begin
    cfg_rdata_o = '0;
    unique case (cfg_addr_i)
      lnps_pkg::REG_RATE: cfg_rdata_o = lnps_pkg::APB_DW'(rate_q);
      lnps_pkg::REG_GAIN: cfg_rdata_o = lnps_pkg::APB_DW'(gain_q);
      default:            cfg_rdata_o = '0;
    endcase
  end

  assign out_sample_o     = o_sample_q;
  assign out_active_o     = o_active_q;
  assign out_peak_o       = o_peak_q;
  assign out_lowest_o     = o_lowest_q;
  assign out_note_valid_o = o_valid_q;

endmodule

>>> design/lowest_note_priority_sine_voice_unit.sv
// From an input beat to a valid result, note on/off and a tick with no note pass through decode
// and output; a tick with a note adds the sine lookup, multiply and rounding; a snapshot adds
// the map scan and, if it finds a note, the serial divide and step load. One item is in work at
// a time; the next beat is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears the held-note map, phase, counts and latches and loads
// the configuration defaults; the block is ready once it is released.
module lowest_note_priority_sine_voice_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  voice_in_if.sink                       in_ch,
  voice_out_if.source                    out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lnps_pkg::APB_AW-1:0]    paddr,
  input  logic [lnps_pkg::APB_DW-1:0]    pwdata,
  output logic [lnps_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  // The controller sequences each item through its steps; the datapath holds the
  // held-note map, the scan and divide registers, the oscillator and the output register.
  lnps_pkg::cmd_t  cmd;
  lnps_pkg::stat_t stat;
  logic            in_ready;
  logic            out_valid;
  logic            cfg_write;

  // Registers are one word apart; a write lands on the access cycle of the transfer.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  lnps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lnps_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_func_i        (in_ch.func),
    .in_note_i        (in_ch.note_number),
    .out_sample_o     (out_ch.sample_value),
    .out_active_o     (out_ch.active_count),
    .out_peak_o       (out_ch.peak_count),
    .out_lowest_o     (out_ch.lowest_note),
    .out_note_valid_o (out_ch.note_valid),
    .cfg_write_i      (cfg_write),
    .cfg_addr_i       (paddr[2]),
    .cfg_wdata_i      (pwdata),
    .cfg_rdata_o      (prdata)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // A sounding sample can only come with a latched note.
  a_sample_needs_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.sample_value != '0)) |-> out_ch.note_valid)
    else $error("nonzero sample without a latched note");

  // The running peak never falls below the current count.
  a_peak_ge_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.peak_count >= out_ch.active_count))
    else $error("peak count below active count");

  // With no note latched, the reported lowest note is zero.
  a_lowest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.note_valid) |-> (out_ch.lowest_note == '0))
    else $error("lowest note set without a latched note");

  // Items are worked one at a time: no beat is taken in the cycle after one is.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

endmodule
